// ----- design/assert_macros.svh -----
// Assertion macros used by the checker in pse_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/pse_pkg.sv -----
package pse_pkg;

    localparam int DEF_STACK_DEPTH = 128;
    localparam int DATA_W          = 32;
    localparam int DEPTH_W         = 8;

    localparam logic [7:0] SYM_ADD   = 8'h2B;
    localparam logic [7:0] SYM_SUB   = 8'h2D;
    localparam logic [7:0] SYM_MUL   = 8'h2A;
    localparam logic [7:0] SYM_DIV   = 8'h2F;
    localparam logic [7:0] SYM_POW   = 8'h5E;
    localparam logic [7:0] SYM_MOD   = 8'h25;
    localparam logic [7:0] SYM_ZERO  = 8'h30;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_MOD,
        OP_POW
    } op_t;

    typedef struct packed {
        logic  start;
        op_t   op;
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic div0;
        logic [DATA_W-1:0] value;
    } alu_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_RHS,
        ST_READ_LHS,
        ST_CALC,
        ST_WAIT,
        ST_WRITE,
        ST_READ_TOP,
        ST_OUT
    } state_t;

endpackage

// ----- design/pse_ram.sv -----
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/pse_alu.sv -----
module pse_alu import pse_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic              busy_reg, busy_next;
    op_t               op_reg, op_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [DATA_W-1:0] a_reg, a_next;     // dividend magnitude / base
    logic [DATA_W-1:0] b_reg, b_next;     // divisor magnitude / exponent
    logic [DATA_W-1:0] acc_reg, acc_next; // remainder / power accumulator
    logic [DATA_W-1:0] q_reg, q_next;     // quotient
    logic              negq_reg, negq_next, negr_reg, negr_next;
    logic              done_reg, done_next, div0_reg, div0_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic [DATA_W:0]   trial;
    logic [DATA_W-1:0] shrem;
    logic [DATA_W-1:0] lmag, rmag;

    assign lmag = req.lhs[DATA_W-1] ? (~req.lhs + 1'b1) : req.lhs;
    assign rmag = req.rhs[DATA_W-1] ? (~req.rhs + 1'b1) : req.rhs;
    assign shrem = {acc_reg[DATA_W-2:0], a_reg[DATA_W-1]};
    assign trial = {1'b0, shrem} - {1'b0, b_reg};

    always_comb
    begin
        busy_next = busy_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        q_next    = q_reg;
        negq_next = negq_reg;
        negr_next = negr_reg;
        done_next = 1'b0;
        div0_next = div0_reg;
        res_next  = res_reg;
        if (req.start)
        begin
            op_next   = req.op;
            div0_next = 1'b0;
            negq_next = req.lhs[DATA_W-1] ^ req.rhs[DATA_W-1];
            negr_next = req.lhs[DATA_W-1];
            busy_next = 1'b0;
            case (req.op)
                OP_ADD:
                begin
                    res_next = req.lhs + req.rhs; done_next = 1'b1;
                end
                OP_SUB:
                begin
                    res_next = req.lhs - req.rhs; done_next = 1'b1;
                end
                OP_MUL:
                begin
                    a_next = req.lhs; b_next = req.rhs; busy_next = 1'b1;
                end
                OP_DIV, OP_MOD:
                begin
                    if (req.rhs == '0)
                    begin
                        res_next = '0; div0_next = 1'b1; done_next = 1'b1;
                    end
                    else
                    begin
                        a_next = lmag; b_next = rmag; acc_next = '0; q_next = '0;
                        cnt_next = 6'(DATA_W); busy_next = 1'b1;
                    end
                end
                OP_POW:
                begin
                    if (req.rhs[DATA_W-1])
                    begin
                        done_next = 1'b1;
                        if (req.lhs == 32'd1)
                            res_next = 32'd1;
                        else if (req.lhs == '1)
                            res_next = req.rhs[0] ? '1 : 32'd1;
                        else
                        begin
                            res_next = '0;
                            div0_next = (req.lhs == '0);
                        end
                    end
                    else
                    begin
                        a_next = req.lhs; b_next = req.rhs; acc_next = 32'd1;
                        busy_next = 1'b1;
                    end
                end
                default:
                begin
                    res_next = '0; done_next = 1'b1;
                end
            endcase
        end
        else if (busy_reg)
        begin
            case (op_reg)
                OP_MUL:
                begin
                    res_next = a_reg * b_reg; done_next = 1'b1; busy_next = 1'b0;
                end
                OP_DIV, OP_MOD:
                begin
                    // one restoring-division bit per cycle
                    if (!trial[DATA_W])
                    begin
                        acc_next = trial[DATA_W-1:0];
                        q_next = {q_reg[DATA_W-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = shrem;
                        q_next = {q_reg[DATA_W-2:0], 1'b0};
                    end
                    a_next = {a_reg[DATA_W-2:0], 1'b0};
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == 6'd0)
                    begin
                        acc_next = acc_reg; q_next = q_reg; a_next = a_reg;
                        cnt_next = cnt_reg;
                        if (op_reg == OP_DIV)
                            res_next = negq_reg ? (~q_reg + 1'b1) : q_reg;
                        else
                            res_next = negr_reg ? (~acc_reg + 1'b1) : acc_reg;
                        done_next = 1'b1; busy_next = 1'b0;
                    end
                end
                OP_POW:
                begin
                    // one square-and-multiply step per cycle
                    if (b_reg == '0)
                    begin
                        res_next = acc_reg; done_next = 1'b1; busy_next = 1'b0;
                    end
                    else
                    begin
                        if (b_reg[0])
                            acc_next = acc_reg * a_reg;
                        a_next = a_reg * a_reg;
                        b_next = b_reg >> 1;
                    end
                end
                default:
                begin
                    busy_next = 1'b0; done_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        cnt_reg  <= cnt_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        q_reg    <= q_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
        div0_reg <= div0_next;
        res_reg  <= res_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.div0  = div0_reg;
    assign rsp.value = res_reg;

endmodule

// ----- design/postfix_stack_evaluator_core.sv -----
// Postfix evaluator: one byte per transfer, one result transfer per byte.
// Operand bytes are pushed without the ALU; + - * / % ^ go through the ALU, with
// ^ taking one square-and-multiply step per cycle over the exponent bits.
// Throughput: one item at a time, set by the stack RAM port and the shared ALU.
// Reset (rst_n, async low) empties the stack; RAM contents stay undefined.
module postfix_stack_evaluator_core import pse_pkg::*; #(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                first,
    input  logic [7:0]          symbol,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  top_value,
    output logic [7:0]          stack_depth,
    output logic                underflow,
    output logic                overflow,
    output logic                divide_by_zero
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;      // stack pointer
    logic [7:0]        sym_reg;
    logic [DATA_W-1:0] rhs_reg, rhs_next, lhs_reg, lhs_next;
    logic              under_reg, under_next, over_reg, over_next;
    logic              div0_reg, div0_next;
    logic [DATA_W-1:0] push_reg, push_next;
    logic              is_op;
    op_t               op_code;
    logic              lhs_pop_reg;            // lhs read came from a real entry

    // RAM side
    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [DATA_W-1:0] wdata, rdata;

    alu_req_t          req;
    alu_rsp_t          rsp;

    // output register
    logic              ov_reg;
    logic [DATA_W-1:0] top_reg;
    logic [7:0]        dep_reg;
    logic              fu_reg, fo_reg, fd_reg;

    assign is_op = (sym_reg inside {SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV, SYM_MOD, SYM_POW});

    always_comb
    begin
        case (sym_reg)
            SYM_ADD: op_code = OP_ADD;
            SYM_SUB: op_code = OP_SUB;
            SYM_MUL: op_code = OP_MUL;
            SYM_DIV: op_code = OP_DIV;
            SYM_MOD: op_code = OP_MOD;
            default: op_code = OP_POW;
        endcase
    end

    pse_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    pse_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // next-state and datapath registers
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rhs_next   = rhs_reg;
        lhs_next   = lhs_reg;
        under_next = under_reg;
        over_next  = over_reg;
        div0_next  = div0_reg;
        push_next  = push_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_READ_RHS;
                    under_next = 1'b0;
                    over_next  = 1'b0;
                    div0_next  = 1'b0;
                    if (first)
                        cnt_next = '0;
                end
            end
            ST_READ_RHS:
            begin
                // address for rhs issued here when operator
                if (is_op)
                begin
                    if (cnt_reg == '0)
                        under_next = 1'b1;
                    else
                        cnt_next = cnt_reg - 1'b1;
                    state_next = ST_READ_LHS;
                end
                else
                begin
                    push_next  = {24'd0, sym_reg} - {24'd0, SYM_ZERO};
                    state_next = ST_WRITE;
                end
            end
            ST_READ_LHS:
            begin
                rhs_next = under_reg ? '1 : rdata;
                if (cnt_reg == '0)
                begin
                    under_next = 1'b1;
                    state_next = ST_CALC;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                // lhs read data valid this cycle (if a pop happened)
                lhs_next   = lhs_pop_reg ? rdata : '1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (rsp.done)
                begin
                    push_next  = rsp.value;
                    div0_next  = rsp.div0;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (cnt_reg >= CW'(STACK_DEPTH))
                    over_next = 1'b1;
                else
                    cnt_next = cnt_reg + 1'b1;
                state_next = ST_READ_TOP;
            end
            ST_READ_TOP:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ov_reg || !out_stall)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // track whether the lhs read came from a real entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lhs_pop_reg <= 1'b0;
        else if (state_reg == ST_READ_LHS)
            lhs_pop_reg <= (cnt_reg != '0);
    end

    // output / control decode
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        we        = 1'b0;
        waddr     = cnt_reg[AW-1:0];
        wdata     = push_reg;
        raddr     = '0;
        req.start = 1'b0;
        req.op    = op_code;
        req.lhs   = lhs_next;
        req.rhs   = rhs_reg;
        case (state_reg)
            ST_READ_RHS:
                raddr = AW'(cnt_reg - 1'b1);
            ST_READ_LHS:
                raddr = AW'(cnt_reg - 1'b1);
            ST_CALC:
                req.start = 1'b1;
            ST_WRITE:
                we = (cnt_reg < CW'(STACK_DEPTH));
            // keep the top entry on the read port while the result waits
            ST_READ_TOP, ST_OUT:
                raddr = AW'(cnt_reg - 1'b1);
            default:
                raddr = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == ST_OUT && (!ov_reg || !out_stall))
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
            sym_reg <= symbol;
        rhs_reg   <= rhs_next;
        lhs_reg   <= lhs_next;
        under_reg <= under_next;
        over_reg  <= over_next;
        div0_reg  <= div0_next;
        push_reg  <= push_next;
        if (state_reg == ST_OUT && (!ov_reg || !out_stall))
        begin
            top_reg <= (cnt_reg == '0) ? '1 : rdata;
            dep_reg <= 8'(cnt_reg);
            fu_reg  <= under_reg;
            fo_reg  <= over_reg;
            fd_reg  <= div0_reg;
        end
    end

    assign out_valid      = ov_reg;
    assign top_value      = top_reg;
    assign stack_depth    = dep_reg;
    assign underflow      = fu_reg;
    assign overflow       = fo_reg;
    assign divide_by_zero = fd_reg;

endmodule

// ----- design/pse_checker.sv -----
`include "assert_macros.svh"
module pse_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] stack_depth,
    input logic       underflow,
    input logic       overflow
);

    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")
    `CHK_IMPLY(a_depth_max, clk, rst_n, out_valid, stack_depth <= 8'd128, "depth beyond capacity")
    `CHK_IMPLY(a_under_depth, clk, rst_n, out_valid && underflow, stack_depth == 8'd1, "underflow leaves one entry")
    `CHK_IMPLY(a_over_full, clk, rst_n, out_valid && overflow, stack_depth == 8'd128, "overflow only when full")
    `CHK_NEXT(a_busy, clk, rst_n, in_valid && !in_stall, in_stall, "second item taken during work")

endmodule

bind postfix_stack_evaluator_core pse_checker u_pse_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .stack_depth (stack_depth),
    .underflow   (underflow),
    .overflow    (overflow)
);
